[design/hnm_pkg.sv]
// shared constants and types for the height to normal map block
package hnm_pkg;

   localparam int POS_W    = 9;
   localparam int HS_W     = 8;
   localparam int SIZE_W   = 10;
   localparam int GAIN_W   = 16;
   localparam int COL_W    = 8;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 2'd0,
      CSR_IMAGE_HEIGHT = 2'd1,
      CSR_BUMP_GAIN    = 2'd2
   } csr_index_type;

   localparam logic FUNC_LOAD   = 1'b0;
   localparam logic FUNC_NORMAL = 1'b1;

   localparam logic [SIZE_W-1:0] RESET_WIDTH  = 10'd512;
   localparam logic [SIZE_W-1:0] RESET_HEIGHT = 10'd512;
   localparam logic [GAIN_W-1:0] RESET_GAIN   = 16'd256;

   // slope: gain*|d| then *512/255 via reciprocal of 255
   localparam int PROD_W  = GAIN_W + HS_W;
   localparam int MAG_W   = PROD_W + 1;
   localparam int RECIP_W = 26;
   localparam int MUL_W   = MAG_W + RECIP_W;
   localparam int RECIP_SHIFT = 33;
   localparam logic [RECIP_W-1:0] RECIP_255 = 26'd33686019;

   // square root of 4.0 + slope^2 in Q16
   localparam int SQR_W     = 2 * MAG_W;
   localparam int RAD_W     = 52;
   localparam int ROOT_W    = 26;
   localparam int REM_W     = 30;
   localparam int SQ_STEPS  = 2;
   localparam int SQ_STAGES = ROOT_W / SQ_STEPS;
   localparam logic [RAD_W-1:0]  RAD_BIAS = 52'h4_0000_0000;
   localparam logic [ROOT_W-1:0] ROOT_MIN = 26'h20000;

   // product of the two roots, split multiplier
   localparam int SPLIT_W = 13;
   localparam int PP_W    = ROOT_W + SPLIT_W;
   localparam int DEN_W   = 52;

   // divider
   localparam int DIV_BITS = 16;
   localparam int NUM_W    = 58;
   localparam int NUM_SHIFT = 33;
   localparam int CMP_W    = DEN_W + DIV_BITS;
   localparam logic [NUM_W-1:0] NZ_NUM = 58'h4_0000_0000_0000;
   localparam logic [DIV_BITS:0] ONE_Q16 = 17'h10000;
   localparam logic [COL_W-1:0]  COL_MID = 8'd127;

endpackage

[design/hnm_ram.sv]
// generic single write, single read ram with registered read data
module hnm_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [DATA_W-1:0]        wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [DATA_W-1:0]        rd_data
);

   logic [DATA_W-1:0] mem [0:DEPTH-1];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[design/height_to_normal_map.sv]
// height to normal map: frame store of heights and a normal-map pixel pipeline
// each compute word strobes one result; load words write the height store and give no result
// throughput: one word per cycle, loads and computes mixed freely; busy stays low
// the four neighbour reads come from four copies of the height store, one port each
// reset clears the pipeline valid bits and sets the registers to 512, 512 and 256
// the height store is not cleared; a sample must be loaded before it is read
module height_to_normal_map #(
   parameter int MAX_WIDTH  = 512,
   parameter int MAX_HEIGHT = 512
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic                             req_func,
   input  logic [hnm_pkg::POS_W-1:0]        req_pos_x,
   input  logic [hnm_pkg::POS_W-1:0]        req_pos_y,
   input  logic [hnm_pkg::HS_W-1:0]         req_height_sample,
   output logic                             rsp_strobe,
   output logic [hnm_pkg::POS_W-1:0]        rsp_out_x,
   output logic [hnm_pkg::POS_W-1:0]        rsp_out_y,
   output logic [hnm_pkg::COL_W-1:0]        rsp_normal_red,
   output logic [hnm_pkg::COL_W-1:0]        rsp_normal_green,
   output logic [hnm_pkg::COL_W-1:0]        rsp_normal_blue,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [hnm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [hnm_pkg::CSR_DATA_W-1:0]   csr_data
);

   localparam int POS_W = hnm_pkg::POS_W;
   localparam int XW    = $clog2(MAX_WIDTH);
   localparam int YW    = $clog2(MAX_HEIGHT);
   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int HW    = $clog2(MAX_HEIGHT + 1);
   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW    = $clog2(DEPTH);
   localparam int MOD_STAGES = 3;
   localparam int MOD_STEPS  = (POS_W + MOD_STAGES - 1) / MOD_STAGES;
   localparam int SQ_STAGES  = hnm_pkg::SQ_STAGES;
   localparam int DIV_BITS   = hnm_pkg::DIV_BITS;
   localparam int MT_SQ_END  = SQ_STAGES + 1;
   localparam int MT_PR      = SQ_STAGES + 3;
   localparam int MT_LAST    = MT_PR + 1 + DIV_BITS;
   localparam int PIPE_LAT   = MT_LAST + 10;

   typedef struct packed {
      logic             func;
      logic [POS_W-1:0] px;
      logic [POS_W-1:0] py;
      logic [hnm_pkg::HS_W-1:0] hs;
      logic [WW-1:0]    w;
      logic [HW-1:0]    h;
      logic [POS_W-1:0] rx;
      logic [POS_W-1:0] ry;
   } front_type;

   typedef struct packed {
      logic             valid;
      logic [POS_W-1:0] px;
      logic [POS_W-1:0] py;
      logic             na;
      logic             nb;
   } early_type;

   typedef struct packed {
      logic                      valid;
      logic [POS_W-1:0]          px;
      logic [POS_W-1:0]          py;
      logic                      na;
      logic                      nb;
      logic [hnm_pkg::MAG_W-1:0] amag;
      logic [hnm_pkg::MAG_W-1:0] bmag;
   } meta_type;

   typedef struct packed {
      logic [hnm_pkg::RAD_W-1:0]  rad;
      logic [hnm_pkg::REM_W-1:0]  rem;
      logic [hnm_pkg::ROOT_W-1:0] root;
   } sq_type;

   typedef struct packed {
      logic [hnm_pkg::NUM_W-1:0] rem;
      logic [DIV_BITS-1:0]       quo;
      logic                      sat;
   } dv_type;

   function automatic logic [WW-1:0] clamp_w(input logic [hnm_pkg::SIZE_W-1:0] v);
      if (v == '0) return WW'(1);
      else if (32'(v) > MAX_WIDTH) return WW'(MAX_WIDTH);
      else return WW'(v);
   endfunction

   function automatic logic [HW-1:0] clamp_h(input logic [hnm_pkg::SIZE_W-1:0] v);
      if (v == '0) return HW'(1);
      else if (32'(v) > MAX_HEIGHT) return HW'(MAX_HEIGHT);
      else return HW'(v);
   endfunction

   // a few restoring steps of pos % size
   function automatic logic [POS_W-1:0] mod_steps(input logic [POS_W-1:0] rem_in,
                                                  input logic [31:0] den, input int top);
      logic [POS_W-1:0] rem;
      int               bit_i;
      rem = rem_in;
      for (int s = 0; s < MOD_STEPS; s++) begin
         bit_i = top - s;
         if (bit_i >= 0) begin
            if (32'(rem) >= (den << bit_i)) begin
               rem = rem - POS_W'(den << bit_i);
            end
         end
      end
      return rem;
   endfunction

   function automatic sq_type sq_steps(input sq_type s_in);
      sq_type                    s;
      logic [hnm_pkg::REM_W-1:0] cur;
      logic [hnm_pkg::REM_W-1:0] trial;
      s = s_in;
      for (int i = 0; i < hnm_pkg::SQ_STEPS; i++) begin
         cur   = {s.rem[hnm_pkg::REM_W-3:0], s.rad[hnm_pkg::RAD_W-1 -: 2]};
         trial = hnm_pkg::REM_W'({s.root, 2'b01});
         if (cur >= trial) begin
            s.rem  = cur - trial;
            s.root = {s.root[hnm_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            s.rem  = cur;
            s.root = {s.root[hnm_pkg::ROOT_W-2:0], 1'b0};
         end
         s.rad = {s.rad[hnm_pkg::RAD_W-3:0], 2'b00};
      end
      return s;
   endfunction

   function automatic dv_type dv_step(input dv_type d_in,
                                      input logic [hnm_pkg::DEN_W-1:0] den, input int bit_i);
      dv_type                    d;
      logic [hnm_pkg::CMP_W-1:0] shifted;
      d       = d_in;
      shifted = hnm_pkg::CMP_W'(den) << bit_i;
      if (!d.sat && (hnm_pkg::CMP_W'(d.rem) >= shifted)) begin
         d.rem        = d.rem - hnm_pkg::NUM_W'(shifted);
         d.quo[bit_i] = 1'b1;
      end
      return d;
   endfunction

   function automatic logic [hnm_pkg::COL_W-1:0] map_channel(input logic neg,
                                                              input logic [DIV_BITS:0] mag);
      logic [DIV_BITS+1:0] v;
      logic [25:0]         sc;
      v  = neg ? (18'(hnm_pkg::ONE_Q16) - 18'(mag)) : (18'(hnm_pkg::ONE_Q16) + 18'(mag));
      sc = 26'(v) * 26'(255);
      return sc[24:17];
   endfunction

   // configuration registers
   logic [hnm_pkg::SIZE_W-1:0] cfg_width_ff;
   logic [hnm_pkg::SIZE_W-1:0] cfg_height_ff;
   logic [hnm_pkg::GAIN_W-1:0] cfg_gain_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_width_ff  <= hnm_pkg::RESET_WIDTH;
         cfg_height_ff <= hnm_pkg::RESET_HEIGHT;
         cfg_gain_ff   <= hnm_pkg::RESET_GAIN;
      end else if (csr_valid && csr_ready) begin
         case (hnm_pkg::csr_index_type'(csr_index))
            hnm_pkg::CSR_IMAGE_WIDTH: begin
               cfg_width_ff <= hnm_pkg::SIZE_W'(csr_data);
            end
            hnm_pkg::CSR_IMAGE_HEIGHT: begin
               cfg_height_ff <= hnm_pkg::SIZE_W'(csr_data);
            end
            hnm_pkg::CSR_BUMP_GAIN: begin
               cfg_gain_ff <= hnm_pkg::GAIN_W'(csr_data);
            end
            default: begin
            end
         endcase
      end
   end

   assign csr_ready = 1'b1;
   assign busy      = 1'b0;

   // front end: capture and reduce position modulo size
   front_type fr_ff       [0:MOD_STAGES];
   logic      fr_valid_ff [0:MOD_STAGES];
   front_type front_in;

   always_comb begin
      front_in.func = req_func;
      front_in.px   = req_pos_x;
      front_in.py   = req_pos_y;
      front_in.hs   = req_height_sample;
      front_in.w    = clamp_w(cfg_width_ff);
      front_in.h    = clamp_h(cfg_height_ff);
      front_in.rx   = req_pos_x;
      front_in.ry   = req_pos_y;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fr_valid_ff[0] <= 1'b0;
      end else begin
         fr_valid_ff[0] <= start && !busy;
      end
      fr_ff[0] <= front_in;
   end

   for (genvar k = 1; k <= MOD_STAGES; k++) begin : g_mod
      localparam int TOP = POS_W - 1 - (k - 1) * MOD_STEPS;
      front_type fr_in;
      always_comb begin
         fr_in    = fr_ff[k-1];
         fr_in.rx = mod_steps(fr_ff[k-1].rx, 32'(fr_ff[k-1].w), TOP);
         fr_in.ry = mod_steps(fr_ff[k-1].ry, 32'(fr_ff[k-1].h), TOP);
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            fr_valid_ff[k] <= 1'b0;
         end else begin
            fr_valid_ff[k] <= fr_valid_ff[k-1];
         end
         fr_ff[k] <= fr_in;
      end
   end

   // neighbour coordinates with wrap
   logic [XW-1:0] cx;
   logic [YW-1:0] cy;
   logic [XW-1:0] xl_in, xr_in;
   logic [YW-1:0] yu_in, yd_in;

   always_comb begin
      cx    = XW'(fr_ff[MOD_STAGES].rx);
      cy    = YW'(fr_ff[MOD_STAGES].ry);
      xr_in = (32'(cx) + 1 == 32'(fr_ff[MOD_STAGES].w)) ? '0 : cx + XW'(1);
      xl_in = (cx == '0) ? XW'(32'(fr_ff[MOD_STAGES].w) - 1) : cx - XW'(1);
      yd_in = (32'(cy) + 1 == 32'(fr_ff[MOD_STAGES].h)) ? '0 : cy + YW'(1);
      yu_in = (cy == '0) ? YW'(32'(fr_ff[MOD_STAGES].h) - 1) : cy - YW'(1);
   end

   logic                     n_valid_ff;
   logic                     n_func_ff;
   logic                     n_wr_ok_ff;
   logic [POS_W-1:0]         n_px_ff, n_py_ff;
   logic [hnm_pkg::HS_W-1:0] n_hs_ff;
   logic [XW-1:0]            n_xl_ff, n_xr_ff;
   logic [YW-1:0]            n_yu_ff, n_yd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         n_valid_ff <= 1'b0;
      end else begin
         n_valid_ff <= fr_valid_ff[MOD_STAGES];
      end
      n_func_ff  <= fr_ff[MOD_STAGES].func;
      n_wr_ok_ff <= (32'(fr_ff[MOD_STAGES].px) < MAX_WIDTH) &&
                    (32'(fr_ff[MOD_STAGES].py) < MAX_HEIGHT);
      n_px_ff    <= fr_ff[MOD_STAGES].px;
      n_py_ff    <= fr_ff[MOD_STAGES].py;
      n_hs_ff    <= fr_ff[MOD_STAGES].hs;
      n_xl_ff    <= xl_in;
      n_xr_ff    <= xr_in;
      n_yu_ff    <= yu_in;
      n_yd_ff    <= yd_in;
   end

   // height store: four copies, each written by every load that falls inside the store, one read port each
   logic                     wr_en;
   logic [AW-1:0]            wr_addr;
   logic [AW-1:0]            rd_addr [0:3];
   logic [hnm_pkg::HS_W-1:0] rd_data [0:3];

   always_comb begin
      wr_en      = n_valid_ff && (n_func_ff == hnm_pkg::FUNC_LOAD) && n_wr_ok_ff;
      wr_addr    = AW'(32'(n_py_ff) * MAX_WIDTH + 32'(n_px_ff));
      rd_addr[0] = AW'(32'(n_yd_ff) * MAX_WIDTH + 32'(n_xl_ff));
      rd_addr[1] = AW'(32'(n_yu_ff) * MAX_WIDTH + 32'(n_xr_ff));
      rd_addr[2] = AW'(32'(n_yu_ff) * MAX_WIDTH + 32'(n_xl_ff));
      rd_addr[3] = AW'(32'(n_yd_ff) * MAX_WIDTH + 32'(n_xr_ff));
   end

   for (genvar i = 0; i < 4; i++) begin : g_store
      hnm_ram #(
         .DATA_W (hnm_pkg::HS_W),
         .DEPTH  (DEPTH)
      ) u_ram (
         .clock   (clock),
         .wr_en   (wr_en),
         .wr_addr (wr_addr),
         .wr_data (n_hs_ff),
         .rd_addr (rd_addr[i]),
         .rd_data (rd_data[i])
      );
   end

   logic             r_valid_ff;
   logic [POS_W-1:0] r_px_ff, r_py_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         r_valid_ff <= 1'b0;
      end else begin
         r_valid_ff <= n_valid_ff && (n_func_ff == hnm_pkg::FUNC_NORMAL);
      end
      r_px_ff <= n_px_ff;
      r_py_ff <= n_py_ff;
   end

   // height differences times gain
   logic [hnm_pkg::HS_W:0]   da, db;
   logic [hnm_pkg::HS_W-1:0] da_abs, db_abs;

   always_comb begin
      da     = {1'b0, rd_data[0]} - {1'b0, rd_data[1]};
      db     = {1'b0, rd_data[2]} - {1'b0, rd_data[3]};
      da_abs = da[hnm_pkg::HS_W] ? hnm_pkg::HS_W'(~da + 1'b1) : hnm_pkg::HS_W'(da);
      db_abs = db[hnm_pkg::HS_W] ? hnm_pkg::HS_W'(~db + 1'b1) : hnm_pkg::HS_W'(db);
   end

   early_type                  g_meta_ff;
   logic [hnm_pkg::PROD_W-1:0] g_pa_ff, g_pb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         g_meta_ff.valid <= 1'b0;
      end else begin
         g_meta_ff.valid <= r_valid_ff;
      end
      g_meta_ff.px <= r_px_ff;
      g_meta_ff.py <= r_py_ff;
      g_meta_ff.na <= da[hnm_pkg::HS_W];
      g_meta_ff.nb <= db[hnm_pkg::HS_W];
      g_pa_ff <= hnm_pkg::PROD_W'(cfg_gain_ff) * hnm_pkg::PROD_W'(da_abs);
      g_pb_ff <= hnm_pkg::PROD_W'(cfg_gain_ff) * hnm_pkg::PROD_W'(db_abs);
   end

   // 2p/255 by reciprocal multiplication, exact over the whole range
   early_type                  q_meta_ff;
   logic [hnm_pkg::PROD_W-1:0] q_pa_ff, q_pb_ff;
   logic [hnm_pkg::MUL_W-1:0]  q_mula_ff, q_mulb_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         q_meta_ff.valid <= 1'b0;
      end else begin
         q_meta_ff.valid <= g_meta_ff.valid;
      end
      q_meta_ff.px <= g_meta_ff.px;
      q_meta_ff.py <= g_meta_ff.py;
      q_meta_ff.na <= g_meta_ff.na;
      q_meta_ff.nb <= g_meta_ff.nb;
      q_pa_ff      <= g_pa_ff;
      q_pb_ff      <= g_pb_ff;
      q_mula_ff    <= hnm_pkg::MUL_W'({g_pa_ff, 1'b0}) * hnm_pkg::MUL_W'(hnm_pkg::RECIP_255);
      q_mulb_ff    <= hnm_pkg::MUL_W'({g_pb_ff, 1'b0}) * hnm_pkg::MUL_W'(hnm_pkg::RECIP_255);
   end

   // metadata line from slope magnitude to the result register
   meta_type meta_ff [0:MT_LAST];
   meta_type meta_in;

   always_comb begin
      meta_in.valid = q_meta_ff.valid;
      meta_in.px    = q_meta_ff.px;
      meta_in.py    = q_meta_ff.py;
      meta_in.na    = q_meta_ff.na;
      meta_in.nb    = q_meta_ff.nb;
      meta_in.amag  = hnm_pkg::MAG_W'({q_pa_ff, 1'b0}) +
                      hnm_pkg::MAG_W'(q_mula_ff[hnm_pkg::MUL_W-1:hnm_pkg::RECIP_SHIFT]);
      meta_in.bmag  = hnm_pkg::MAG_W'({q_pb_ff, 1'b0}) +
                      hnm_pkg::MAG_W'(q_mulb_ff[hnm_pkg::MUL_W-1:hnm_pkg::RECIP_SHIFT]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         meta_ff[0] <= '0;
      end else begin
         meta_ff[0] <= meta_in;
      end
   end

   for (genvar k = 1; k <= MT_LAST; k++) begin : g_meta
      always_ff @(posedge clock) begin
         if (reset) begin
            meta_ff[k] <= '0;
         end else begin
            meta_ff[k] <= meta_ff[k-1];
         end
      end
   end

   // square roots, two lanes, two result bits per stage
   sq_type sq_ff [0:SQ_STAGES][0:1];

   for (genvar l = 0; l < 2; l++) begin : g_sq_lane
      logic [hnm_pkg::MAG_W-1:0] mag;
      logic [hnm_pkg::SQR_W-1:0] sqr;
      sq_type                    sq0_in;
      always_comb begin
         mag         = (l == 0) ? meta_ff[0].amag : meta_ff[0].bmag;
         sqr         = hnm_pkg::SQR_W'(mag) * hnm_pkg::SQR_W'(mag);
         sq0_in.rad  = hnm_pkg::RAD_BIAS + hnm_pkg::RAD_W'(sqr);
         sq0_in.rem  = '0;
         sq0_in.root = '0;
      end
      always_ff @(posedge clock) begin
         sq_ff[0][l] <= sq0_in;
      end
      for (genvar k = 1; k <= SQ_STAGES; k++) begin : g_sq_stage
         always_ff @(posedge clock) begin
            sq_ff[k][l] <= sq_steps(sq_ff[k-1][l]);
         end
      end
   end

   // product of the roots from two partial products
   logic [hnm_pkg::ROOT_W-1:0] sa, sb;
   logic [hnm_pkg::PP_W-1:0]   pp_lo_ff, pp_hi_ff;
   logic [hnm_pkg::DEN_W-1:0]  pr_ff;

   assign sa = sq_ff[SQ_STAGES][0].root;
   assign sb = sq_ff[SQ_STAGES][1].root;

   always_ff @(posedge clock) begin
      pp_lo_ff <= hnm_pkg::PP_W'(sa) * hnm_pkg::PP_W'(sb[hnm_pkg::SPLIT_W-1:0]);
      pp_hi_ff <= hnm_pkg::PP_W'(sa) *
                  hnm_pkg::PP_W'(sb[hnm_pkg::ROOT_W-1:hnm_pkg::SPLIT_W]);
      pr_ff    <= hnm_pkg::DEN_W'(pp_lo_ff) +
                  (hnm_pkg::DEN_W'(pp_hi_ff) << hnm_pkg::SPLIT_W);
   end

   // dividers, three lanes sharing the denominator, one quotient bit per stage
   dv_type                    dv_ff     [0:DIV_BITS][0:2];
   logic [hnm_pkg::DEN_W-1:0] dv_den_ff [0:DIV_BITS];

   always_ff @(posedge clock) begin
      dv_den_ff[0] <= pr_ff;
   end

   for (genvar l = 0; l < 3; l++) begin : g_dv_lane
      logic [hnm_pkg::NUM_W-1:0] num;
      dv_type                    dv0_in;
      always_comb begin
         case (l)
            0: num = {meta_ff[MT_PR].amag, hnm_pkg::NUM_SHIFT'(0)};
            1: num = {meta_ff[MT_PR].bmag, hnm_pkg::NUM_SHIFT'(0)};
            default: num = hnm_pkg::NZ_NUM;
         endcase
         dv0_in.rem = num;
         dv0_in.quo = '0;
         // quotient at or above one saturates
         dv0_in.sat = hnm_pkg::CMP_W'(num) >= {pr_ff, DIV_BITS'(0)};
      end
      always_ff @(posedge clock) begin
         dv_ff[0][l] <= dv0_in;
      end
      for (genvar j = 1; j <= DIV_BITS; j++) begin : g_dv_stage
         always_ff @(posedge clock) begin
            dv_ff[j][l] <= dv_step(dv_ff[j-1][l], dv_den_ff[j-1], DIV_BITS - j);
         end
      end
   end

   for (genvar j = 1; j <= DIV_BITS; j++) begin : g_dv_den
      always_ff @(posedge clock) begin
         dv_den_ff[j] <= dv_den_ff[j-1];
      end
   end

   // channel mapping and result register
   logic [DIV_BITS:0] mag_x, mag_y, mag_z;

   always_comb begin
      mag_x = dv_ff[DIV_BITS][0].sat ? hnm_pkg::ONE_Q16 : {1'b0, dv_ff[DIV_BITS][0].quo};
      mag_y = dv_ff[DIV_BITS][1].sat ? hnm_pkg::ONE_Q16 : {1'b0, dv_ff[DIV_BITS][1].quo};
      mag_z = dv_ff[DIV_BITS][2].sat ? hnm_pkg::ONE_Q16 : {1'b0, dv_ff[DIV_BITS][2].quo};
   end

   logic                      rsp_strobe_ff;
   logic [POS_W-1:0]          rsp_x_ff, rsp_y_ff;
   logic [hnm_pkg::COL_W-1:0] rsp_red_ff, rsp_green_ff, rsp_blue_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= meta_ff[MT_LAST].valid;
      end
      rsp_x_ff     <= meta_ff[MT_LAST].px;
      rsp_y_ff     <= meta_ff[MT_LAST].py;
      // normal x,y point against the slope
      rsp_red_ff   <= map_channel(!meta_ff[MT_LAST].na, mag_x);
      rsp_green_ff <= map_channel(!meta_ff[MT_LAST].nb, mag_y);
      rsp_blue_ff  <= map_channel(1'b0, mag_z);
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_out_x        = rsp_x_ff;
   assign rsp_out_y        = rsp_y_ff;
   assign rsp_normal_red   = rsp_red_ff;
   assign rsp_normal_green = rsp_green_ff;
   assign rsp_normal_blue  = rsp_blue_ff;

   a_rsp_from_compute: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && (req_func == hnm_pkg::FUNC_NORMAL), PIPE_LAT))
      else $error("result without a matching compute word");

   a_rsp_position: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_out_x == $past(req_pos_x, PIPE_LAT)) &&
                     (rsp_out_y == $past(req_pos_y, PIPE_LAT)))
      else $error("result position does not match its request");

   a_blue_up: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> rsp_normal_blue >= hnm_pkg::COL_MID)
      else $error("blue channel below the midpoint");

   a_root_floor: assert property (@(posedge clock) disable iff (reset)
      meta_ff[MT_SQ_END].valid |-> (sa >= hnm_pkg::ROOT_MIN) && (sb >= hnm_pkg::ROOT_MIN))
      else $error("square root below two");

endmodule
